// ===== sv/srw_pkg.sv =====
// shared types and constants of the selective repeat window block
`timescale 1ns / 1ps

package srw_pkg;

   // fixed field widths
   localparam int SEQ_W      = 10;
   localparam int TOT_W      = 11;
   localparam int BASE_W     = 11;
   localparam int WS_W       = 7;
   localparam int STATUS_W   = 3;
   localparam int TRIES_W    = 8;
   localparam int PSUM_W     = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // widest window the scan covers
   localparam int MAX_WINDOW = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IBASE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WSIZE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLE   = 2'd3;

   typedef enum logic [1:0] {
      OP_NEXT   = 2'd0,
      OP_ACK    = 2'd1,
      OP_RESEND = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PKT_PENDING = 2'd0,
      PKT_SENT    = 2'd1,
      PKT_DONE    = 2'd2
   } pkt_state_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 3'd0,
      ST_NONE = 3'd1,
      ST_OOW  = 3'd2,
      ST_DUP  = 3'd3,
      ST_REJ  = 3'd4
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clr_init;
      logic clr_step;
      logic fetch;
      logic check;
      logic scan_init;
      logic scan_step;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic ack_go;
      logic scan_done;
   } stat_type;

endpackage

// ===== sv/srw_dpath.sv =====
// datapath: config registers, packet state memory, window scan and result registers
`timescale 1ns / 1ps

module srw_dpath #(
   parameter int MAX_PACKETS = 1024,
   parameter int TRY_BITS    = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  srw_pkg::cmd_type                  cmd,
   output srw_pkg::stat_type                 stat,
   input  logic [1:0]                        req_opcode,
   input  logic [srw_pkg::SEQ_W-1:0]         req_seq,
   input  logic                              csr_we,
   input  logic [srw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [srw_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic [srw_pkg::STATUS_W-1:0]      rsp_status,
   output logic [srw_pkg::SEQ_W-1:0]         rsp_position,
   output logic [srw_pkg::WS_W-1:0]          rsp_advanced,
   output logic [srw_pkg::TRIES_W-1:0]       rsp_tries,
   output logic [srw_pkg::TOT_W-1:0]         rsp_outstanding,
   output logic [srw_pkg::BASE_W-1:0]        rsp_base_now
);

   localparam int AW = $clog2(MAX_PACKETS);
   localparam int EW = TRY_BITS + 2;

   // configuration and window state
   logic [srw_pkg::TOT_W-1:0]  total_ff;
   logic [srw_pkg::SEQ_W-1:0]  ibase_ff;
   logic [srw_pkg::WS_W-1:0]   wsize_ff;
   logic [srw_pkg::BASE_W-1:0] base_ff;
   logic [srw_pkg::TOT_W-1:0]  remain_ff;
   logic [AW-1:0]              clr_ff;

   // item under work
   srw_pkg::op_type            op_ff;
   logic [srw_pkg::SEQ_W-1:0]  seq_ff;
   srw_pkg::status_type        status_ff;
   logic [srw_pkg::SEQ_W-1:0]  pos_ff;
   logic [srw_pkg::WS_W-1:0]   adv_ff;
   logic [srw_pkg::TRIES_W-1:0] tries_ff;

   // scan pipeline
   logic [srw_pkg::WS_W-1:0]   scan_i_ff;
   logic [srw_pkg::WS_W-1:0]   chk_off_ff;
   logic                       chk_vld_ff;

   // state memory: {state, tries}
   logic [EW-1:0]              mem [MAX_PACKETS];
   logic [EW-1:0]              rd_ff;

   logic [srw_pkg::TOT_W-1:0]  tot_eff;
   logic [srw_pkg::WS_W-1:0]   ws_eff;
   logic [srw_pkg::PSUM_W-1:0] tot_ext;
   logic [srw_pkg::PSUM_W-1:0] base_ext;
   logic [srw_pkg::PSUM_W-1:0] seq_ext;
   logic [srw_pkg::PSUM_W-1:0] win_end;
   logic [srw_pkg::PSUM_W-1:0] scan_p;
   logic [srw_pkg::PSUM_W-1:0] chk_p;
   srw_pkg::pkt_state_type     rd_state;
   logic [TRY_BITS-1:0]        rd_try;
   logic [TRY_BITS-1:0]        try_inc;
   logic [srw_pkg::TRIES_W-1:0] tries_sat;
   logic                       oow;
   logic                       ack_go;
   logic                       resend_ok;
   logic                       next_mode;
   logic                       in_range;
   logic                       hit;
   logic                       scan_done;
   logic [srw_pkg::WS_W-1:0]   adv_calc;
   logic                       mem_we;
   logic [AW-1:0]              mem_wa;
   logic [EW-1:0]              mem_wd;
   logic                       mem_re;
   logic [AW-1:0]              mem_ra;

   always_comb begin
      tot_eff = (32'(total_ff) > 32'(MAX_PACKETS)) ?
                srw_pkg::TOT_W'(MAX_PACKETS) : total_ff;
      ws_eff  = (wsize_ff > srw_pkg::WS_W'(srw_pkg::MAX_WINDOW)) ?
                srw_pkg::WS_W'(srw_pkg::MAX_WINDOW) : wsize_ff;
      tot_ext  = srw_pkg::PSUM_W'(tot_eff);
      base_ext = srw_pkg::PSUM_W'(base_ff);
      seq_ext  = srw_pkg::PSUM_W'(seq_ff);
      win_end  = base_ext + srw_pkg::PSUM_W'(ws_eff);
      scan_p   = base_ext + srw_pkg::PSUM_W'(scan_i_ff);
      chk_p    = base_ext + srw_pkg::PSUM_W'(chk_off_ff);

      rd_state = srw_pkg::pkt_state_type'(rd_ff[EW-1 -: 2]);
      rd_try   = rd_ff[TRY_BITS-1:0];
      try_inc  = (rd_try == '1) ? rd_try : rd_try + TRY_BITS'(1);
      tries_sat = (32'(try_inc) > 32'd255) ? 8'd255 : srw_pkg::TRIES_W'(try_inc);

      oow       = (seq_ext < base_ext) || (seq_ext >= win_end) || (seq_ext >= tot_ext);
      ack_go    = (op_ff == srw_pkg::OP_ACK) && !oow && (rd_state != srw_pkg::PKT_DONE);
      resend_ok = (seq_ext < tot_ext) && (rd_state == srw_pkg::PKT_SENT);

      // next-to-send looks for pending, ack slide looks for not done
      next_mode = (op_ff == srw_pkg::OP_NEXT);
      in_range  = (scan_i_ff < ws_eff) && (scan_p < tot_ext);
      hit       = chk_vld_ff && (next_mode ? (rd_state == srw_pkg::PKT_PENDING)
                                           : (rd_state != srw_pkg::PKT_DONE));
      scan_done = hit || !in_range;
      adv_calc  = hit ? chk_off_ff : scan_i_ff;
   end

   assign stat.clr_last  = (clr_ff == AW'(MAX_PACKETS - 1));
   assign stat.ack_go    = ack_go;
   assign stat.scan_done = scan_done;

   // write port select
   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      priority if (cmd.clr_step) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
      end else if (cmd.check && ack_go) begin
         mem_we = 1'b1;
         mem_wa = AW'(seq_ff);
         mem_wd = {srw_pkg::PKT_DONE, rd_try};
      end else if (cmd.check && (op_ff == srw_pkg::OP_RESEND) && resend_ok) begin
         mem_we = 1'b1;
         mem_wa = AW'(seq_ff);
         mem_wd = {srw_pkg::PKT_PENDING, rd_try};
      end else if (cmd.scan_step && next_mode && hit) begin
         mem_we = 1'b1;
         mem_wa = AW'(chk_p);
         mem_wd = {srw_pkg::PKT_SENT, try_inc};
      end else begin
         mem_we = 1'b0;
      end
      mem_re = cmd.fetch || cmd.scan_step;
      mem_ra = cmd.fetch ? AW'(seq_ff) : AW'(scan_p);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= 11'd1024;
         ibase_ff  <= '0;
         wsize_ff  <= 7'd8;
         base_ff   <= '0;
         remain_ff <= 11'd1024;
         clr_ff    <= '0;
      end else begin
         if (cmd.clr_init) begin
            clr_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_ff <= clr_ff + AW'(1);
         end

         if (csr_we) begin
            unique case (csr_index)
               srw_pkg::CSR_TOTAL: begin
                  total_ff  <= csr_wdata;
                  remain_ff <= csr_wdata;
                  base_ff   <= srw_pkg::BASE_W'(ibase_ff);
               end
               srw_pkg::CSR_IBASE: begin
                  ibase_ff  <= csr_wdata[srw_pkg::SEQ_W-1:0];
                  base_ff   <= srw_pkg::BASE_W'(csr_wdata[srw_pkg::SEQ_W-1:0]);
                  remain_ff <= total_ff;
               end
               srw_pkg::CSR_WSIZE: begin
                  wsize_ff <= csr_wdata[srw_pkg::WS_W-1:0];
               end
               // both roles mark any packet not yet done, so role changes nothing
               srw_pkg::CSR_ROLE: begin
                  wsize_ff <= wsize_ff;
               end
               default: begin
                  wsize_ff <= wsize_ff;
               end
            endcase
         end else begin
            if (cmd.check && ack_go && (remain_ff != '0)) begin
               remain_ff <= remain_ff - srw_pkg::TOT_W'(1);
            end
            if (cmd.scan_step && scan_done && !next_mode) begin
               base_ff <= base_ff + srw_pkg::BASE_W'(adv_calc);
            end
         end
      end
   end

   // item and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= srw_pkg::op_type'(req_opcode);
         seq_ff    <= req_seq;
         status_ff <= srw_pkg::ST_OK;
         pos_ff    <= ((req_opcode == srw_pkg::OP_ACK) || (req_opcode == srw_pkg::OP_RESEND)) ?
                      req_seq : '0;
         adv_ff    <= '0;
         tries_ff  <= '0;
      end
      if (cmd.check) begin
         if (op_ff == srw_pkg::OP_ACK) begin
            if (oow) begin
               status_ff <= srw_pkg::ST_OOW;
            end else if (rd_state == srw_pkg::PKT_DONE) begin
               status_ff <= srw_pkg::ST_DUP;
            end
         end else if (!resend_ok) begin
            status_ff <= srw_pkg::ST_REJ;
         end
      end
      if (cmd.scan_step && scan_done) begin
         if (next_mode) begin
            if (hit) begin
               pos_ff   <= srw_pkg::SEQ_W'(chk_p);
               tries_ff <= tries_sat;
            end else begin
               status_ff <= srw_pkg::ST_NONE;
            end
         end else begin
            adv_ff <= adv_calc;
         end
      end

      if (cmd.scan_init) begin
         scan_i_ff  <= '0;
         chk_vld_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         chk_vld_ff <= in_range;
         chk_off_ff <= scan_i_ff;
         if (in_range) begin
            scan_i_ff <= scan_i_ff + srw_pkg::WS_W'(1);
         end
      end

      if (cmd.out_load) begin
         rsp_status      <= status_ff;
         rsp_position    <= pos_ff;
         rsp_advanced    <= adv_ff;
         rsp_tries       <= tries_ff;
         rsp_outstanding <= remain_ff;
         rsp_base_now    <= base_ff;
      end
   end

endmodule

// ===== sv/srw_ctrl.sv =====
// controller: sequences clearing, lookup, window scan and result handoff
`timescale 1ns / 1ps

module srw_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          csr_we,
   input  logic [srw_pkg::CSR_IDX_W-1:0] csr_index,
   input  srw_pkg::stat_type             stat,
   output srw_pkg::cmd_type              cmd
);

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_FETCH  = 6'b000100,
      S_CHECK  = 6'b001000,
      S_SCAN   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      restart;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign restart   = csr_we && ((csr_index == srw_pkg::CSR_TOTAL) ||
                                 (csr_index == srw_pkg::CSR_IBASE));

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load      = 1'b1;
               cmd.scan_init = 1'b1;
               unique case (srw_pkg::op_type'(req_opcode))
                  srw_pkg::OP_NEXT:   state_in = S_SCAN;
                  srw_pkg::OP_ACK:    state_in = S_FETCH;
                  srw_pkg::OP_RESEND: state_in = S_FETCH;
                  srw_pkg::OP_NOP:    state_in = S_FINISH;
                  default:            state_in = S_FINISH;
               endcase
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            cmd.check     = 1'b1;
            cmd.scan_init = 1'b1;
            state_in      = stat.ack_go ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      // restart wipes the state memory again
      if (restart) begin
         cmd.clr_init = 1'b1;
         cmd.clr_step = 1'b0;
         state_in     = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/selective_repeat_window.sv =====
// top level of the selective repeat window bookkeeping block
`timescale 1ns / 1ps

// usage
//   req channel (req_valid/req_ready) carries one item: opcode and seq
//     next to send picks the first pending packet in the window and marks it sent
//     ack/receive marks an in-window packet done and slides the base
//     resend puts a sent packet back to pending
//   rsp channel (rsp_valid/rsp_ready) returns exactly one item per request
//   csr port: csr_we, csr_index, csr_wdata; writes are registered, no read-back
//     writing total_packets or initial_base restarts the transfer
// sequencing, one item at a time
//   next to send: window scan, finish; ack: fetch, check, window scan if accepted, finish;
//   resend: fetch, check, finish; unused opcode: finish
//   the window scan reads one state memory entry per cycle through its single
//   read port; each entry read is registered before it is checked
// reset and restart
//   a clearing pass walks all MAX_PACKETS state memory entries, one entry per cycle;
//   req_ready stays low until it ends, csr writes are still taken
// stalls
//   the result sits in an output register; a new item is taken while it waits,
//   and a finished item holds in the controller until the register frees up

module selective_repeat_window #(
   parameter int MAX_PACKETS = 1024,
   parameter int TRY_BITS    = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request items
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_opcode,
   input  logic [srw_pkg::SEQ_W-1:0]         req_seq,
   // response items
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [srw_pkg::STATUS_W-1:0]      rsp_status,
   output logic [srw_pkg::SEQ_W-1:0]         rsp_position,
   output logic [srw_pkg::WS_W-1:0]          rsp_advanced,
   output logic [srw_pkg::TRIES_W-1:0]       rsp_tries,
   output logic [srw_pkg::TOT_W-1:0]         rsp_outstanding,
   output logic [srw_pkg::BASE_W-1:0]        rsp_base_now,
   // configuration writes
   input  logic                              csr_we,
   input  logic [srw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [srw_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   srw_pkg::cmd_type  cmd;
   srw_pkg::stat_type stat;

   // sequencing: clear pass, lookup, scan, result handoff
   srw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .stat       (stat),
      .cmd        (cmd)
   );

   // state memory, window registers and the output register
   srw_dpath #(
      .MAX_PACKETS (MAX_PACKETS),
      .TRY_BITS    (TRY_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_seq         (req_seq),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_advanced    (rsp_advanced),
      .rsp_tries       (rsp_tries),
      .rsp_outstanding (rsp_outstanding),
      .rsp_base_now    (rsp_base_now)
   );

endmodule

// ===== test/selective_repeat_window_tb.sv =====
// self-checking testbench for the selective repeat window block
`timescale 1ns / 1ps

module selective_repeat_window_tb;
   import srw_pkg::*;

   // depth of the packet state store in the block
   localparam int STORE_DEPTH = 1024;
   // far above the slowest correct run, clearing passes included
   localparam int CYCLE_LIMIT = 2000000;
   // items to push through before the run winds down
   localparam int ITEM_TARGET = 1900;

   // one response item as the block presents it
   typedef struct packed {
      status_type           status;
      logic [SEQ_W-1:0]     position;
      logic [WS_W-1:0]      advanced;
      logic [TRIES_W-1:0]   tries;
      logic [TOT_W-1:0]     outstanding;
      logic [BASE_W-1:0]    base_now;
   } window_result_type;

   // mirror of the window bookkeeping plus the responses still owed
   class window_book;
      logic [TOT_W-1:0]     total_reg;
      logic [SEQ_W-1:0]     ibase_reg;
      logic [WS_W-1:0]      wsize_reg;
      logic                 role_reg;
      pkt_state_type        pkt [STORE_DEPTH];
      logic [TRIES_W-1:0]   try_cnt [STORE_DEPTH];
      int                   base;
      int                   remaining;
      window_result_type    due_results [$];
      int                   fail_count;

      function new();
         total_reg  = 11'd1024;
         ibase_reg  = '0;
         wsize_reg  = 7'd8;
         role_reg   = 1'b0;
         fail_count = 0;
         restart();
      endfunction

      // a new transfer: every packet pending, counts cleared
      function void restart();
         foreach (pkt[i]) begin
            pkt[i]     = PKT_PENDING;
            try_cnt[i] = '0;
         end
         base      = int'(ibase_reg);
         remaining = int'(total_reg);
      endfunction

      // totals past the store depth act as the store depth
      function int span_total();
         return (total_reg > STORE_DEPTH) ? STORE_DEPTH : int'(total_reg);
      endfunction

      function int span_window();
         return (wsize_reg > MAX_WINDOW) ? MAX_WINDOW : int'(wsize_reg);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TOTAL: begin
               total_reg = data[TOT_W-1:0];
               restart();
            end
            CSR_IBASE: begin
               ibase_reg = data[SEQ_W-1:0];
               restart();
            end
            CSR_WSIZE: wsize_reg = data[WS_W-1:0];
            CSR_ROLE:  role_reg = data[0];
            default: ;
         endcase
      endfunction

      // work out the response of one accepted request and queue it
      function void take_request(op_type op, logic [SEQ_W-1:0] seq);
         window_result_type r;
         int tot, ws, s, p, i, adv;
         r = '0;
         r.status = ST_OK;
         tot = span_total();
         ws = span_window();
         s = int'(seq);
         adv = 0;
         case (op)
            OP_NEXT: begin
               r.status = ST_NONE;
               for (i = 0; i < ws && base + i < tot; i++) begin
                  p = base + i;
                  if (pkt[p] == PKT_PENDING) begin
                     pkt[p] = PKT_SENT;
                     if (try_cnt[p] != {TRIES_W{1'b1}})
                        try_cnt[p] = try_cnt[p] + 1'b1;
                     r.position = p[SEQ_W-1:0];
                     r.tries = try_cnt[p];
                     r.status = ST_OK;
                     break;
                  end
               end
            end
            OP_ACK: begin
               // both roles take any packet that is not yet done
               r.position = seq;
               if (s < base || s >= base + ws || s >= tot)
                  r.status = ST_OOW;
               else if (pkt[s] == PKT_DONE)
                  r.status = ST_DUP;
               else begin
                  pkt[s] = PKT_DONE;
                  if (remaining > 0)
                     remaining--;
                  for (i = 0; i < ws && base + i < tot; i++) begin
                     if (pkt[base + i] != PKT_DONE)
                        break;
                     adv++;
                  end
                  base += adv;
                  r.advanced = adv[WS_W-1:0];
               end
            end
            OP_RESEND: begin
               r.position = seq;
               if (s >= tot || pkt[s] != PKT_SENT)
                  r.status = ST_REJ;
               else
                  pkt[s] = PKT_PENDING;
            end
            default: ;
         endcase
         r.outstanding = remaining[TOT_W-1:0];
         r.base_now = base[BASE_W-1:0];
         due_results.push_back(r);
      endfunction

      // compare one response with the oldest one owed
      function void match_response(window_result_type got);
         window_result_type want;
         if (due_results.size() == 0) begin
            if (fail_count < 10)
               $display("response with no request waiting: st=%0d pos=%0d base=%0d",
                        got.status, got.position, got.base_now);
            fail_count++;
            return;
         end
         want = due_results.pop_front();
         if (got.status !== want.status || got.position !== want.position ||
             got.advanced !== want.advanced || got.tries !== want.tries ||
             got.outstanding !== want.outstanding || got.base_now !== want.base_now) begin
            if (fail_count < 10) begin
               $display("mismatch expected st=%0d pos=%0d adv=%0d tries=%0d out=%0d base=%0d",
                        want.status, want.position, want.advanced, want.tries,
                        want.outstanding, want.base_now);
               $display("         actual   st=%0d pos=%0d adv=%0d tries=%0d out=%0d base=%0d",
                        got.status, got.position, got.advanced, got.tries,
                        got.outstanding, got.base_now);
            end
            fail_count++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [1:0]              req_opcode;
   logic [SEQ_W-1:0]        req_seq;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [STATUS_W-1:0]     rsp_status;
   logic [SEQ_W-1:0]        rsp_position;
   logic [WS_W-1:0]         rsp_advanced;
   logic [TRIES_W-1:0]      rsp_tries;
   logic [TOT_W-1:0]        rsp_outstanding;
   logic [BASE_W-1:0]       rsp_base_now;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   window_book book;
   // set for a whole phase: neither side inserts idle cycles
   bit steady;
   int sent_items;
   int cycle_count;

   selective_repeat_window uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_seq         (req_seq),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_advanced    (rsp_advanced),
      .rsp_tries       (rsp_tries),
      .rsp_outstanding (rsp_outstanding),
      .rsp_base_now    (rsp_base_now),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle cycles before the next item on either side
   function int pause_len();
      return steady ? 0 : $urandom_range(0, 6);
   endfunction

   // drive one request item; valid holds until the handshake
   task automatic issue(op_type op, logic [SEQ_W-1:0] seq);
      int gap;
      gap = pause_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_seq    <= seq;
      do @(posedge clock); while (!req_ready);
      book.take_request(op, seq);
      if (op != OP_NOP)
         sent_items++;
   endtask

   // register write; csr_we drops before the task returns, so back to back writes never collide
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      book.write_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // stop sending and let every owed response come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.due_results.size() != 0) @(posedge clock);
   endtask

   // ack target: mostly inside the window, some at its edges, some anywhere
   function automatic logic [SEQ_W-1:0] pick_ack_seq();
      int tot, ws, b, span, roll;
      tot = book.span_total();
      ws = book.span_window();
      b = book.base;
      roll = $urandom_range(0, 9);
      if (ws == 0 || b >= tot || roll == 0)
         return SEQ_W'($urandom_range(0, 1023));
      if (roll == 1)
         return SEQ_W'(b + ws);
      if (roll == 2)
         return SEQ_W'(b - 1);
      span = (tot - b < ws) ? tot - b : ws;
      return SEQ_W'(b + $urandom_range(0, span - 1));
   endfunction

   // resend target: mostly a packet that is out on the wire
   function automatic logic [SEQ_W-1:0] pick_resend_seq();
      int tot, ws, i;
      int sent_q [$];
      tot = book.span_total();
      ws = book.span_window();
      for (i = 0; i < ws && book.base + i < tot; i++)
         if (book.pkt[book.base + i] == PKT_SENT)
            sent_q.push_back(book.base + i);
      if (sent_q.size() > 0 && $urandom_range(0, 4) != 0)
         return SEQ_W'(sent_q[$urandom_range(0, sent_q.size() - 1)]);
      return pick_ack_seq();
   endfunction

   // new window settings for a phase, usually with a fresh transfer
   task automatic new_settings();
      int w, t, b, roll;
      steady = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 9);
      if (roll == 0)
         w = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 64 : 127);
      else if (roll < 5)
         w = $urandom_range(1, 8);
      else
         w = $urandom_range(1, 64);
      write_reg(CSR_WSIZE, CSR_DATA_W'(w));
      // the mirror keeps only the low bit of the role register; the block ignores it
      if ($urandom_range(0, 1) == 0)
         write_reg(CSR_ROLE, CSR_DATA_W'($urandom_range(0, 2047)));
      if ($urandom_range(0, 4) != 0) begin
         roll = $urandom_range(0, 9);
         if (roll == 0)
            case ($urandom_range(0, 4))
               0: t = 0;
               1: t = 1;
               2: t = 1024;
               3: t = 2047;
               default: t = $urandom_range(0, 2047);
            endcase
         else
            t = $urandom_range(1, 150);
         roll = $urandom_range(0, 9);
         if (roll < 5 || t < 2)
            b = 0;
         else if (roll < 9)
            b = $urandom_range(0, (t > 1024 ? 1024 : t) - 1);
         else
            b = $urandom_range(0, 1023);
         write_reg(CSR_TOTAL, CSR_DATA_W'(t));
         write_reg(CSR_IBASE, CSR_DATA_W'(b));
      end
   endtask

   // a stretch of traffic: mostly sensible sends, acks and resends, some noise
   task automatic run_phase(int n);
      int k, roll;
      k = 0;
      while (k < n) begin
         roll = $urandom_range(0, 99);
         if (roll >= 85 && roll < 92)
            issue(OP_NOP, SEQ_W'($urandom_range(0, 1023)));
         else begin
            if (roll < 40)
               issue(OP_NEXT, SEQ_W'($urandom_range(0, 1023)));
            else if (roll < 72)
               issue(OP_ACK, pick_ack_seq());
            else if (roll < 85)
               issue(OP_RESEND, pick_resend_seq());
            else
               issue(op_type'($urandom_range(1, 2)), SEQ_W'($urandom_range(0, 1023)));
            k++;
         end
      end
   endtask

   // response side: random stalls, check each item as it is taken
   initial begin
      window_result_type got;
      int stall;
      wait (reset === 1'b0);
      forever begin
         stall = pause_len();
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.status      = status_type'(rsp_status);
         got.position    = rsp_position;
         got.advanced    = rsp_advanced;
         got.tries       = rsp_tries;
         got.outstanding = rsp_outstanding;
         got.base_now    = rsp_base_now;
         book.match_response(got);
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("selective_repeat_window_tb: errors");
      $finish;
   end

   initial begin
      int n;
      book = new();
      steady = 1'b0;
      sent_items = 0;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_opcode <= OP_NOP;
      req_seq    <= '0;
      rsp_ready  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_TOTAL;
      csr_wdata  <= '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: sends, resend of sent / pending / far packets,
      // ack out of order, duplicate, slide, out of window, unused opcode
      issue(OP_NEXT, 10'd0);
      issue(OP_NEXT, 10'd0);
      issue(OP_RESEND, 10'd1);
      issue(OP_RESEND, 10'd1);
      issue(OP_RESEND, 10'd5);
      issue(OP_ACK, 10'd2);
      issue(OP_ACK, 10'd2);
      issue(OP_ACK, 10'd0);
      issue(OP_ACK, 10'h3FF);
      issue(OP_RESEND, 10'h3FF);
      issue(OP_NOP, 10'h3FF);
      wait_idle();

      // receiver, one-packet window, short transfer run to its end
      write_reg(CSR_WSIZE, 11'd1);
      write_reg(CSR_ROLE, 11'd1);
      write_reg(CSR_TOTAL, 11'd3);
      issue(OP_NEXT, 10'd0);
      issue(OP_NEXT, 10'd0);
      issue(OP_ACK, 10'd0);
      issue(OP_ACK, 10'd1);
      issue(OP_ACK, 10'd2);
      issue(OP_NEXT, 10'd0);
      issue(OP_ACK, 10'd3);
      wait_idle();

      // empty transfer and empty window
      write_reg(CSR_TOTAL, 11'd0);
      write_reg(CSR_WSIZE, 11'd0);
      issue(OP_NEXT, 10'd0);
      issue(OP_ACK, 10'd0);
      issue(OP_RESEND, 10'd0);
      wait_idle();

      // oversized total and window, base at the top of the range
      write_reg(CSR_TOTAL, 11'h7FF);
      write_reg(CSR_IBASE, 11'h3FF);
      write_reg(CSR_WSIZE, 11'h7F);
      write_reg(CSR_ROLE, 11'd0);
      issue(OP_NEXT, 10'd0);
      issue(OP_ACK, 10'h3FF);
      issue(OP_NEXT, 10'd0);
      wait_idle();

      // hammer one packet with send / resend until its try count pins
      write_reg(CSR_TOTAL, 11'd2);
      write_reg(CSR_IBASE, 11'd0);
      write_reg(CSR_WSIZE, 11'd1);
      steady = ($urandom_range(0, 1) == 0);
      repeat (258) begin
         issue(OP_NEXT, SEQ_W'($urandom_range(0, 1023)));
         issue(OP_RESEND, 10'd0);
      end
      wait_idle();

      // random phases until enough items have gone through
      while (sent_items < ITEM_TARGET) begin
         new_settings();
         n = $urandom_range(30, 120);
         run_phase(n);
         wait_idle();
      end

      // room for any stray response to show up
      repeat (80) @(posedge clock);
      if (book.fail_count == 0 && book.due_results.size() == 0)
         $display("selective_repeat_window_tb: clean");
      else
         $display("selective_repeat_window_tb: errors");
      $finish;
   end

endmodule
